FILE: rtl/core/utcfo_pkg.sv
// ---------------------------------------------------------------------------
// utcfo_pkg
// Types, constants and calendar helpers for the fixed-offset time converter.
// ---------------------------------------------------------------------------
package utcfo_pkg;

  localparam int YearW  = 8;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int HourW  = 5;

  // direction codes
  localparam logic KindToLocal = 1'b0;
  localparam logic KindToUtc   = 1'b1;

  localparam int BaseYear = 2000;

  localparam logic [HourW-1:0]  HourShift     = HourW'(8);
  localparam logic [HourW:0]    HoursPerDay   = (HourW+1)'(24);
  localparam logic [HourW-1:0]  HourBorrowAdd = HourW'(24 - 8);
  localparam logic [MonthW:0]   MonthsPerYear = (MonthW+1)'(12);
  localparam logic [MonthW-1:0] MonthLast     = MonthW'(12);
  localparam logic [MonthW-1:0] MonthFirst    = MonthW'(1);
  localparam logic [DayW-1:0]   DayFirst      = DayW'(1);

  localparam logic [MonthW-1:0] MonFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonApr = MonthW'(4);
  localparam logic [MonthW-1:0] MonJun = MonthW'(6);
  localparam logic [MonthW-1:0] MonSep = MonthW'(9);
  localparam logic [MonthW-1:0] MonNov = MonthW'(11);

  // century years in range that are not leap years (2400 lies beyond the wrap)
  localparam logic [YearW-1:0] Century2100 = YearW'(2100 - BaseYear);
  localparam logic [YearW-1:0] Century2200 = YearW'(2200 - BaseYear);

  typedef struct packed {
    logic              kind;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
  } utcfo_item_t;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
  } utcfo_res_t;

  function automatic logic is_leap(input logic [YearW-1:0] year);
    // base year is a multiple of 400, so the low two bits decide divisibility by 4
    return (year[1:0] == 2'b00) && (year != Century2100) && (year != Century2200);
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [YearW-1:0]  year,
                                                input logic [MonthW-1:0] month);
    logic [DayW-1:0] len;
    len = DayW'(31);
    if (month == MonFeb) begin
      len = is_leap(year) ? DayW'(29) : DayW'(28);
    end else if (month == MonApr || month == MonJun || month == MonSep ||
                 month == MonNov) begin
      len = DayW'(30);
    end
    return len;
  endfunction

endpackage

FILE: rtl/core/utcfo_if.sv
// ---------------------------------------------------------------------------
// utcfo channel interfaces
// Valid/ready channels for date-hour items and converted results.
// ---------------------------------------------------------------------------
interface utcfo_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] year;
  logic [3:0] month;
  logic [4:0] day;
  logic [4:0] hour;

  modport source (output valid, kind, year, month, day, hour, input ready);
  modport sink   (input valid, kind, year, month, day, hour, output ready);
endinterface

interface utcfo_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_year;
  logic [3:0] out_month;
  logic [4:0] out_day;
  logic [4:0] out_hour;

  modport source (output valid, out_year, out_month, out_day, out_hour, input ready);
  modport sink   (input valid, out_year, out_month, out_day, out_hour, output ready);
endinterface

FILE: rtl/core/utcfo_shift.sv
// ---------------------------------------------------------------------------
// utcfo_shift
// Eight-hour shift of a date and hour with day, month and year carry/borrow.
// ---------------------------------------------------------------------------
module utcfo_shift (
  input  utcfo_pkg::utcfo_item_t item,
  output utcfo_pkg::utcfo_res_t  res
);
  import utcfo_pkg::*;

  logic [HourW:0]    hr_sum;
  logic              hr_carry;
  logic [DayW:0]     day_inc;
  logic              day_over;
  logic [MonthW:0]   mon_inc;
  logic              mon_over;
  logic [DayW-1:0]   len_cur;
  logic              hr_borrow;
  logic              day_low;
  logic              mon_low;
  logic [MonthW-1:0] mon_prev;
  logic [YearW-1:0]  yr_prev;
  logic [DayW-1:0]   len_prev;

  always_comb begin
    // forward path
    hr_sum   = {1'b0, item.hour} + {1'b0, HourShift};
    hr_carry = (hr_sum >= HoursPerDay);
    len_cur  = month_len(item.year, item.month);
    day_inc  = {1'b0, item.day} + (DayW+1)'(1);
    day_over = (day_inc > {1'b0, len_cur});
    mon_inc  = {1'b0, item.month} + (MonthW+1)'(1);
    mon_over = (mon_inc > MonthsPerYear);

    // backward path
    hr_borrow = (item.hour < HourShift);
    day_low   = (item.day <= DayFirst);
    mon_low   = (item.month <= MonthFirst);
    mon_prev  = mon_low ? MonthLast : item.month - MonthFirst;
    yr_prev   = mon_low ? item.year - YearW'(1) : item.year;
    len_prev  = month_len(yr_prev, mon_prev);

    res.year  = item.year;
    res.month = item.month;
    res.day   = item.day;
    res.hour  = item.hour;

    if (item.kind == KindToLocal) begin
      if (hr_carry) begin
        res.hour = HourW'(hr_sum - HoursPerDay);
        if (day_over) begin
          res.day = DayFirst;
          if (mon_over) begin
            res.month = MonthFirst;
            res.year  = item.year + YearW'(1);
          end else begin
            res.month = mon_inc[MonthW-1:0];
          end
        end else begin
          res.day = day_inc[DayW-1:0];
        end
      end else begin
        res.hour = hr_sum[HourW-1:0];
      end
    end else begin
      if (hr_borrow) begin
        res.hour = item.hour + HourBorrowAdd;
        if (day_low) begin
          res.month = mon_prev;
          res.year  = yr_prev;
          res.day   = len_prev;
        end else begin
          res.day = item.day - DayFirst;
        end
      end else begin
        res.hour = item.hour - HourShift;
      end
    end
  end

endmodule

FILE: rtl/core/utc_fixed_offset_time_convert_top.sv
// ---------------------------------------------------------------------------
// utc_fixed_offset_time_convert_top
// Shifts a date and hour by eight hours, UTC to local or local to UTC.
// ---------------------------------------------------------------------------
//  channel  | port    | direction | payload
//  ---------+---------+-----------+------------------------------------------
//  input    | in_ch   | sink      | kind, year, month, day, hour
//  result   | out_ch  | source    | out_year, out_month, out_day, out_hour
//
//  one transfer per cycle in each direction while the result is not stalled;
//  input register, then result register, with the date logic between them
//  ready runs backward through both stages, so a stalled result holds the
//  result register and the input register keeps taking items until both fill
//  synchronous active-low reset empties both stages
// ---------------------------------------------------------------------------
module utc_fixed_offset_time_convert_top (
  input logic        clk,
  input logic        rst_n,
  utcfo_in_if.sink   in_ch,
  utcfo_out_if.source out_ch
);
  import utcfo_pkg::*;

  logic        s1_valid_r;
  utcfo_item_t s1_item_r;
  logic        out_valid_r;
  utcfo_res_t  out_res_r;
  utcfo_res_t  res_c;
  logic        s1_adv;
  logic        in_xfer;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.kind  <= in_ch.kind;
      s1_item_r.year  <= in_ch.year;
      s1_item_r.month <= in_ch.month;
      s1_item_r.day   <= in_ch.day;
      s1_item_r.hour  <= in_ch.hour;
    end
    if (s1_adv && s1_valid_r) begin
      out_res_r <= res_c;
    end
  end

  utcfo_shift u_shift (
    .item (s1_item_r),
    .res  (res_c)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_year  = out_res_r.year;
  assign out_ch.out_month = out_res_r.month;
  assign out_ch.out_day   = out_res_r.day;
  assign out_ch.out_hour  = out_res_r.hour;

  // shifted hour always lands inside a day
  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.hour < HourW'(24)))
    else $error("converted hour out of range");

  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted item lost before input register");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input register changed while result stalled");

  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv) |=> out_valid_r)
    else $error("item dropped between stages");

endmodule
